FILE: design/prpt_pkg.sv
// Package for the padded rectangle placement table.
// Holds widths, register indexes, reset values and the shared types.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package prpt_pkg;

   localparam int MAX_RECTS      = 16;
   localparam int TRIES_PER_RECT = 30;

   localparam int IDX_W   = $clog2(MAX_RECTS);
   localparam int CNT_W   = $clog2(MAX_RECTS + 1);
   localparam int TRY_W   = $clog2(MAX_RECTS * TRIES_PER_RECT + 1);
   localparam int COORD_W = 11;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_ADDR_W-1:0] REG_MAP_WIDTH   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_MAP_HEIGHT  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_PADDING     = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_ROOM_TARGET = 2'd3;

   localparam logic [7:0] MAP_WIDTH_RST   = 8'd50;
   localparam logic [7:0] MAP_HEIGHT_RST  = 8'd50;
   localparam logic [3:0] PADDING_RST     = 4'd1;
   localparam logic [4:0] ROOM_TARGET_RST = 5'd16;

   localparam logic ACTION_START = 1'b0;

   // Candidate or stored rectangle, x in the lowest byte.
   typedef struct packed {
      logic [7:0] height;
      logic [7:0] width;
      logic [7:0] z;
      logic [7:0] x;
   } rect_type;

   // Padded candidate edges, inclusive, signed.
   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] right;
      logic signed [COORD_W-1:0] top;
      logic signed [COORD_W-1:0] bottom;
   } bounds_type;

   // Verdict that walks down the row of cells.
   typedef struct packed {
      logic valid;
      logic ok;
   } token_type;

   // Result beat, placed in the lowest bit.
   typedef struct packed {
      logic             finished;
      logic [CNT_W-1:0] stored_count;
      logic             placed;
   } result_type;

endpackage

`default_nettype wire

FILE: design/prpt_cell.sv
// One cell of the placement table: stores one rectangle and checks it
// against the padded candidate as the verdict token passes. Uses prpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prpt_cell (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         live,
   input  wire                         wr_en,
   input  wire prpt_pkg::rect_type     wr_rect,
   input  wire prpt_pkg::bounds_type   cand,
   input  wire prpt_pkg::token_type    tok_in,
   output prpt_pkg::token_type         tok_out
);
   import prpt_pkg::*;

   rect_type  rect_ff;
   token_type tok_ff;
   token_type tok_in_n;
   logic signed [COORD_W-1:0] o_left, o_right, o_top, o_bottom;
   logic apart;

   always_comb begin
      o_left   = COORD_W'(rect_ff.x);
      o_top    = COORD_W'(rect_ff.z);
      o_right  = COORD_W'(rect_ff.x) + COORD_W'(rect_ff.width) - COORD_W'(1);
      o_bottom = COORD_W'(rect_ff.z) + COORD_W'(rect_ff.height) - COORD_W'(1);
      apart = (cand.right < o_left) || (cand.left > o_right) ||
              (cand.bottom < o_top) || (cand.top > o_bottom);
      tok_in_n.valid = tok_in.valid;
      tok_in_n.ok    = tok_in.ok && (!live || apart);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rect_ff <= wr_rect;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_n;
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

FILE: design/padded_rectangle_placement_table.sv
// Top level of the padded rectangle placement table.
// Instantiates the row of prpt_cell stages; uses prpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

// How to use this block.
// The req channel carries one beat per item. req_tuser is the action: a low
// value starts a new level, which empties the table and clears the try count;
// a high value offers the candidate rectangle in req_tdata. The rsp channel
// returns exactly one beat per request beat with the placed flag, the number
// of stored rectangles and the finished flag.
// A candidate is padded on every side and its edges are computed as the beat
// is taken. The verdict then walks through a row of sixteen cells, one cell
// per cycle, each cell holding one stored rectangle. At the end of the row
// the counters and the table are updated and the result is written out.
// One item is handled at a time, so a new request beat is taken only after
// the verdict of the previous one has left the last cell of the row.
// A finished result sits in the output register while the next request is
// already accepted. When the receiver holds rsp_tready low, one more result
// fits in a second register; beyond that req_tready stays low.
// Reset empties the table, clears both counters and loads the register
// defaults: map 50 by 50, padding 1, target 16. The user must write the csr
// port registers only while no item is in flight; the block does not check.
module padded_rectangle_placement_table (
   input  wire                                  clock,
   input  wire                                  reset,
   // Configuration writes.
   input  wire                                  csr_we,
   input  wire  [prpt_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire  [prpt_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // Request stream.
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [31:0]                          req_tdata, // cand_x, cand_z, cand_width, cand_height
   input  wire                                  req_tuser, // action
   // Result stream.
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [7:0]                           rsp_tdata  // placed, stored_count, finished, zero pad
);
   import prpt_pkg::*;

   // Configuration registers.
   logic [7:0] map_width_ff, map_height_ff;
   logic [3:0] padding_ff;
   logic [4:0] room_target_ff;

   // Level state and the item in flight.
   logic [CNT_W-1:0] count_ff, count_in;
   logic [TRY_W-1:0] tries_ff, tries_in;
   logic             busy_ff, busy_in;
   logic             action_ff;
   rect_type         cand_ff;
   bounds_type       bounds_ff, bounds_in;
   token_type        head_ff, head_in;

   // Output register and its skid entry.
   result_type rsp_data_ff, pend_data_ff, result;
   logic       rsp_valid_ff, pend_valid_ff;

   token_type            chain [MAX_RECTS+1];
   logic [MAX_RECTS-1:0] wr_vec;
   logic [MAX_RECTS-1:0] live_vec;
   logic [MAX_RECTS:0]   tok_valid_vec;

   rect_type         req_rect;
   logic             req_take, rsp_take, commit, placed, done_now, map_ok;
   logic [CNT_W-1:0] target;
   logic [TRY_W-1:0] limit;

   assign req_rect   = rect_type'(req_tdata);
   assign req_tready = !busy_ff && !pend_valid_ff;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_take   = rsp_valid_ff && rsp_tready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff   <= MAP_WIDTH_RST;
         map_height_ff  <= MAP_HEIGHT_RST;
         padding_ff     <= PADDING_RST;
         room_target_ff <= ROOM_TARGET_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_MAP_WIDTH:   map_width_ff   <= csr_wdata[7:0];
            REG_MAP_HEIGHT:  map_height_ff  <= csr_wdata[7:0];
            REG_PADDING:     padding_ff     <= csr_wdata[3:0];
            REG_ROOM_TARGET: room_target_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // Padded edges of the incoming candidate and the map bound check. Edges
   // can go negative or beyond 255, so they are carried as signed values.
   always_comb begin
      bounds_in.left   = COORD_W'(req_rect.x) - COORD_W'(padding_ff);
      bounds_in.top    = COORD_W'(req_rect.z) - COORD_W'(padding_ff);
      bounds_in.right  = COORD_W'(req_rect.x) + COORD_W'(req_rect.width) +
                         COORD_W'(padding_ff) - COORD_W'(1);
      bounds_in.bottom = COORD_W'(req_rect.z) + COORD_W'(req_rect.height) +
                         COORD_W'(padding_ff) - COORD_W'(1);
      map_ok = !bounds_in.left[COORD_W-1] && !bounds_in.top[COORD_W-1] &&
               (bounds_in.right  < $signed(COORD_W'(map_width_ff))) &&
               (bounds_in.bottom < $signed(COORD_W'(map_height_ff)));
      head_in.valid = req_take;
      head_in.ok    = map_ok;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cand_ff   <= req_rect;
         action_ff <= req_tuser;
         bounds_ff <= bounds_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else begin
         head_ff <= head_in;
      end
   end

   // The row of cells. Cell i holds table entry i and only counts as a
   // blocker while i is below the stored count.
   assign chain[0] = head_ff;

   for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
      assign live_vec[i]      = count_ff > CNT_W'(i);
      assign wr_vec[i]        = placed && (count_ff[IDX_W-1:0] == IDX_W'(i));
      assign tok_valid_vec[i] = chain[i].valid;

      prpt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .live    (live_vec[i]),
         .wr_en   (wr_vec[i]),
         .wr_rect (cand_ff),
         .cand    (bounds_ff),
         .tok_in  (chain[i]),
         .tok_out (chain[i+1])
      );
   end
   assign tok_valid_vec[MAX_RECTS] = chain[MAX_RECTS].valid;

   // Target is capped at the table size; the try limit follows from it.
   assign target = (room_target_ff > 5'(MAX_RECTS)) ? CNT_W'(MAX_RECTS)
                                                    : CNT_W'(room_target_ff);
   assign limit    = TRY_W'(target) * TRY_W'(TRIES_PER_RECT);
   assign done_now = (count_ff >= target) || (tries_ff >= limit);
   assign commit   = chain[MAX_RECTS].valid;

   // Level update when the verdict leaves the last cell.
   always_comb begin
      count_in = count_ff;
      tries_in = tries_ff;
      placed   = 1'b0;
      busy_in  = busy_ff;
      if (req_take) begin
         busy_in = 1'b1;
      end
      if (commit) begin
         busy_in = 1'b0;
         if (action_ff == ACTION_START) begin
            count_in = '0;
            tries_in = '0;
         end else if (!done_now) begin
            tries_in = tries_ff + TRY_W'(1);
            if (chain[MAX_RECTS].ok && (count_ff < CNT_W'(MAX_RECTS))) begin
               placed   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
      end
      result.placed       = placed;
      result.stored_count = count_in;
      result.finished     = (count_in >= target) || (tries_in >= limit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         tries_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         tries_ff <= tries_in;
         busy_ff  <= busy_in;
      end
   end

   // Output register with one skid entry. A result lands in the skid entry
   // only when the output register is full and not being drained.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (!rsp_valid_ff || rsp_take) begin
            if (pend_valid_ff) begin
               rsp_valid_ff  <= 1'b1;
               pend_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= commit;
            end
         end else if (commit) begin
            pend_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_take) begin
         if (pend_valid_ff) begin
            rsp_data_ff <= pend_data_ff;
         end else if (commit) begin
            rsp_data_ff <= result;
         end
      end else if (commit) begin
         pend_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   // The skid entry is only ever filled behind a full output register.
   a_pend_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> rsp_valid_ff)
      else $error("skid entry holds a result while the output register is empty");

   // At most one verdict token travels down the row.
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid_vec))
      else $error("more than one token in the cell row");

   // A placement raises the stored count by exactly one.
   a_place_count: assert property (@(posedge clock) disable iff (reset)
      (commit && placed) |=> (count_ff == CNT_W'($past(count_ff) + CNT_W'(1))))
      else $error("stored count did not step on a placement");

   // The stored count never exceeds the table size.
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RECTS))
      else $error("stored count beyond table size");

endmodule

`default_nettype wire
